@@ sv/lsse_pkg.sv @@
// ----------------------------------------------------------------------------
// lsse_pkg
// Shared constants, types and helpers of the forward-Euler plant step unit.
// ----------------------------------------------------------------------------
package lsse_pkg;

  // model dimensions and number format
  localparam int MAX_STATES  = 4;
  localparam int MAX_INPUTS  = 2;
  localparam int MAX_OUTPUTS = 2;
  localparam int FRAC_BITS   = 16;

  // products summed by one lane per phase
  localparam int NUM_TERMS = MAX_STATES + MAX_INPUTS;
  localparam int KW        = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;
  localparam int SW        = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int IW        = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int LANES     = (MAX_OUTPUTS > MAX_STATES) ? MAX_OUTPUTS : MAX_STATES;

  // accumulator: 64-bit products shifted right, a few of them summed
  localparam int ACC_W = 64 - FRAC_BITS + 4;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7fff_ffff);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_COEF = 2'd0,
    OP_INIT = 2'd1,
    OP_STEP = 2'd2,
    OP_NOP  = 2'd3   // reserved, ignored
  } op_e;

  // coefficient matrix select codes
  localparam logic [1:0] MAT_A = 2'd0;
  localparam logic [1:0] MAT_B = 2'd1;
  localparam logic [1:0] MAT_C = 2'd2;
  localparam logic [1:0] MAT_D = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_STATE_COUNT  = 2'd0;
  localparam logic [1:0] REG_INPUT_COUNT  = 2'd1;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd2;
  localparam logic [1:0] REG_STEP_SIZE    = 2'd3;

  // per-lane control from the sequencer
  typedef struct packed {
    logic clr;
    logic en;
  } lane_ctrl_t;

  // saturate an accumulator value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fff_ffff;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/lsse_lane.sv @@
// ----------------------------------------------------------------------------
// lsse_lane
// One multiply-accumulate lane: registered 32x32 product, floor shift by the
// fraction bits, exact accumulation.
// ----------------------------------------------------------------------------
module lsse_lane import lsse_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctrl_t              ctrl_i,
  input  logic signed [31:0]      op_a_i,
  input  logic signed [31:0]      op_b_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [63:0]      prod_d;
  logic signed [63:0]      prod_q;
  logic                    prod_vld_q;
  logic signed [ACC_W-1:0] acc_q;

  // full product of the two operands
  assign prod_d = op_a_i * op_b_i;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // accumulate stage, arithmetic shift truncates toward minus infinity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q >>> FRAC_BITS);
    end
  end

  assign acc_o = acc_q;

endmodule

@@ sv/lti_state_space_euler_step_unit.sv @@
// ----------------------------------------------------------------------------
// lti_state_space_euler_step_unit
// Forward-Euler LTI plant step in Q16.16 with one MAC lane per state row.
// ----------------------------------------------------------------------------
// Usage:
// - cfg channel (cfg_valid_i/cfg_ready_o) writes state_count, input_count,
//   output_count and step_size; it is always ready.
// - in channel takes coefficient loads, initial-state loads and step
//   transactions. Loads finish in the accept cycle and give no result.
// - a step transaction busies the block after the accept with these phases:
//   issue of A*x + B*u, drain, the dt product, drain, issue of C*x' + D*u,
//   drain. The four lanes each run one 32x32 multiplier, so the term
//   count per row sets the length of each issue phase. A new step is
//   taken only once the block is back in idle.
// - the result sits in an output register; a new transaction is accepted
//   while it waits. A step completing while the previous result is still
//   untaken holds in its last drain cycle until the receiver takes it.
// - reset zeroes all coefficients and state, sets counts to 4/2/2 and
//   step_size to 655, and marks the model uninitialized.
// ----------------------------------------------------------------------------
module lti_state_space_euler_step_unit import lsse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [1:0]         matrix_select_i,
  input  logic [1:0]         row_i,
  input  logic [1:0]         col_i,
  input  logic signed [31:0] load_value_i,
  input  logic               restart_i,
  input  logic signed [31:0] drive_0_i,
  input  logic signed [31:0] drive_1_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] state_0_o,
  output logic signed [31:0] state_1_o,
  output logic signed [31:0] state_2_o,
  output logic signed [31:0] state_3_o,
  output logic signed [31:0] plant_out_0_o,
  output logic signed [31:0] plant_out_1_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_XISS,
    S_XWAIT,
    S_DISS,
    S_DWAIT,
    S_YISS,
    S_YWAIT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [2:0]  cfg_n_q;
  logic [1:0]  cfg_m_q;
  logic [1:0]  cfg_p_q;
  logic [30:0] step_q;

  // coefficient and state storage
  logic signed [31:0] a_q [MAX_STATES][MAX_STATES];
  logic signed [31:0] b_q [MAX_STATES][MAX_INPUTS];
  logic signed [31:0] c_q [MAX_OUTPUTS][MAX_STATES];
  logic signed [31:0] d_q [MAX_OUTPUTS][MAX_INPUTS];
  logic signed [31:0] init_vec_q [MAX_STATES];
  logic signed [31:0] cur_q [MAX_STATES];
  logic               init_q;

  // per-step working registers
  logic [2:0]         n_q;
  logic [1:0]         p_q;
  logic signed [31:0] u_q [MAX_INPUTS];
  logic signed [31:0] deriv_q [LANES];
  logic [KW-1:0]      k_q;
  logic               w_q;

  // result registers
  logic               out_valid_q;
  logic signed [31:0] res_x_q [MAX_STATES];
  logic signed [31:0] res_y_q [MAX_OUTPUTS];

  // lane signals
  lane_ctrl_t              lane_ctrl;
  logic signed [31:0]      op_a [LANES];
  logic signed [31:0]      op_b [LANES];
  logic signed [ACC_W-1:0] acc [LANES];

  logic               in_fire;
  logic               step_fire;
  logic [2:0]         n_clamp;
  logic [1:0]         m_clamp;
  logic [1:0]         p_clamp;
  logic [SW-1:0]      kx;
  logic [IW-1:0]      kj;
  logic [KW-1:0]      kj_full;
  logic               k_is_state;
  logic               k_active;
  logic               out_free;
  logic               res_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign step_fire   = in_fire && (operation_i == OP_STEP);
  assign out_free    = !out_valid_q || out_ready_i;
  assign res_load    = (state_q == S_YWAIT) && w_q && out_free;

  // count clamping
  always_comb begin
    n_clamp = cfg_n_q;
    if (cfg_n_q == 3'd0) begin
      n_clamp = 3'd1;
    end else if (int'(cfg_n_q) > MAX_STATES) begin
      n_clamp = 3'(MAX_STATES);
    end
    m_clamp = cfg_m_q;
    if (cfg_m_q == 2'd0) begin
      m_clamp = 2'd1;
    end else if (int'(cfg_m_q) > MAX_INPUTS) begin
      m_clamp = 2'(MAX_INPUTS);
    end
    p_clamp = cfg_p_q;
    if (cfg_p_q == 2'd0) begin
      p_clamp = 2'd1;
    end else if (int'(cfg_p_q) > MAX_OUTPUTS) begin
      p_clamp = 2'(MAX_OUTPUTS);
    end
  end

  // term index decode
  assign k_is_state = int'(k_q) < MAX_STATES;
  assign kx         = k_q[SW-1:0];
  assign kj_full    = k_q - KW'(MAX_STATES);
  assign kj         = kj_full[IW-1:0];
  assign k_active   = int'(k_q) < int'(n_q);

  // lane control
  assign lane_ctrl.en  = (state_q == S_XISS) || (state_q == S_DISS) || (state_q == S_YISS);
  assign lane_ctrl.clr = (state_q == S_IDLE) ||
                         (((state_q == S_XWAIT) || (state_q == S_DWAIT)) && w_q);

  // lanes with their operand selection
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    // output row served by this lane, kept in range for lanes without one
    localparam int GY = (g < MAX_OUTPUTS) ? g : 0;

    always_comb begin
      op_a[g] = '0;
      op_b[g] = '0;
      case (state_q)
        S_XISS: begin
          if (g < MAX_STATES) begin
            if (k_is_state) begin
              op_a[g] = k_active ? a_q[g][kx] : 32'sd0;
              op_b[g] = cur_q[kx];
            end else begin
              op_a[g] = b_q[g][kj];
              op_b[g] = u_q[kj];
            end
          end
        end
        S_DISS: begin
          op_a[g] = deriv_q[g];
          op_b[g] = $signed({1'b0, step_q});
        end
        S_YISS: begin
          if (g < MAX_OUTPUTS) begin
            if (k_is_state) begin
              op_a[g] = k_active ? c_q[GY][kx] : 32'sd0;
              op_b[g] = cur_q[kx];
            end else begin
              op_a[g] = d_q[GY][kj];
              op_b[g] = u_q[kj];
            end
          end
        end
        default: begin
          op_a[g] = '0;
          op_b[g] = '0;
        end
      endcase
    end

    lsse_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl),
      .op_a_i (op_a[g]),
      .op_b_i (op_b[g]),
      .acc_o  (acc[g])
    );
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_n_q <= 3'd4;
      cfg_m_q <= 2'd2;
      cfg_p_q <= 2'd2;
      step_q  <= 31'd655;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STATE_COUNT:  cfg_n_q <= cfg_data_i[2:0];
        REG_INPUT_COUNT:  cfg_m_q <= cfg_data_i[1:0];
        REG_OUTPUT_COUNT: cfg_p_q <= cfg_data_i[1:0];
        REG_STEP_SIZE:    step_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // coefficient and initial-state loads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_STATES; i++) begin
        for (int j = 0; j < MAX_STATES; j++) a_q[i][j] <= '0;
        for (int j = 0; j < MAX_INPUTS; j++) b_q[i][j] <= '0;
        init_vec_q[i] <= '0;
      end
      for (int i = 0; i < MAX_OUTPUTS; i++) begin
        for (int j = 0; j < MAX_STATES; j++) c_q[i][j] <= '0;
        for (int j = 0; j < MAX_INPUTS; j++) d_q[i][j] <= '0;
      end
    end else if (in_fire) begin
      if (operation_i == OP_COEF) begin
        for (int i = 0; i < MAX_STATES; i++) begin
          for (int j = 0; j < MAX_STATES; j++) begin
            if (matrix_select_i == MAT_A && int'(row_i) == i && int'(col_i) == j) begin
              a_q[i][j] <= load_value_i;
            end
          end
          for (int j = 0; j < MAX_INPUTS; j++) begin
            if (matrix_select_i == MAT_B && int'(row_i) == i && int'(col_i) == j) begin
              b_q[i][j] <= load_value_i;
            end
          end
        end
        for (int i = 0; i < MAX_OUTPUTS; i++) begin
          for (int j = 0; j < MAX_STATES; j++) begin
            if (matrix_select_i == MAT_C && int'(row_i) == i && int'(col_i) == j) begin
              c_q[i][j] <= load_value_i;
            end
          end
          for (int j = 0; j < MAX_INPUTS; j++) begin
            if (matrix_select_i == MAT_D && int'(row_i) == i && int'(col_i) == j) begin
              d_q[i][j] <= load_value_i;
            end
          end
        end
      end else if (operation_i == OP_INIT) begin
        for (int i = 0; i < MAX_STATES; i++) begin
          if (int'(row_i) == i) begin
            init_vec_q[i] <= load_value_i;
          end
        end
      end
    end
  end

  // step sequencer, state vector and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      init_q      <= 1'b0;
      n_q         <= 3'd1;
      p_q         <= 2'd1;
      k_q         <= '0;
      w_q         <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_STATES; i++) cur_q[i] <= '0;
    end else begin
      // result valid: set on a merge, cleared once taken
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (step_fire) begin
            if (restart_i || !init_q) begin
              for (int i = 0; i < MAX_STATES; i++) cur_q[i] <= init_vec_q[i];
            end
            init_q  <= 1'b1;
            n_q     <= n_clamp;
            p_q     <= p_clamp;
            k_q     <= '0;
            state_q <= S_XISS;
          end
        end
        S_XISS: begin
          if (int'(k_q) == NUM_TERMS - 1) begin
            w_q     <= 1'b0;
            state_q <= S_XWAIT;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        S_XWAIT: begin
          if (w_q) begin
            w_q     <= 1'b0;
            state_q <= S_DISS;
          end else begin
            w_q <= 1'b1;
          end
        end
        S_DISS: begin
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (w_q) begin
            // x' = sat(x + floor(deriv * dt)) for active rows only
            for (int i = 0; i < MAX_STATES; i++) begin
              if (i < int'(n_q)) begin
                cur_q[i] <= sat32(ACC_W'(cur_q[i]) + acc[i]);
              end
            end
            w_q     <= 1'b0;
            k_q     <= '0;
            state_q <= S_YISS;
          end else begin
            w_q <= 1'b1;
          end
        end
        S_YISS: begin
          if (int'(k_q) == NUM_TERMS - 1) begin
            w_q     <= 1'b0;
            state_q <= S_YWAIT;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        S_YWAIT: begin
          if (!w_q) begin
            w_q <= 1'b1;
          end else if (out_free) begin
            w_q     <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // drive vector latched at step accept, inactive inputs zeroed
  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      for (int j = 0; j < MAX_INPUTS; j++) begin
        if (j == 0 && j < int'(m_clamp)) begin
          u_q[j] <= drive_0_i;
        end else if (j == 1 && j < int'(m_clamp)) begin
          u_q[j] <= drive_1_i;
        end else begin
          u_q[j] <= '0;
        end
      end
    end
  end

  // saturated derivative per lane
  always_ff @(posedge clk_i) begin
    if (state_q == S_XWAIT && w_q) begin
      for (int i = 0; i < LANES; i++) deriv_q[i] <= sat32(acc[i]);
    end
  end

  // merge of lane results into the output register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      for (int i = 0; i < MAX_STATES; i++) begin
        res_x_q[i] <= (i < int'(n_q)) ? cur_q[i] : 32'sd0;
      end
      for (int i = 0; i < MAX_OUTPUTS; i++) begin
        res_y_q[i] <= (i < int'(p_q)) ? sat32(acc[i]) : 32'sd0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign state_0_o     = res_x_q[0];
  assign state_1_o     = res_x_q[1];
  assign state_2_o     = res_x_q[2];
  assign state_3_o     = res_x_q[3];
  assign plant_out_0_o = res_y_q[0];
  assign plant_out_1_o = res_y_q[1];

`ifndef SYNTHESIS
  // a step transaction keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> !in_ready_o)
    else $error("step accepted without entering the busy sequence");

  // active state count stays within the lane range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q != 3'd0) && (int'(n_q) <= MAX_STATES))
    else $error("active state count out of range");

  // once initialized the model never drops back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(init_q))
    else $error("initialized flag cleared");

  // a new result only appears at the end of the output phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_YWAIT)
    else $error("result raised outside the output phase");
`endif

endmodule
